/* sv/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, color constants and key function for the grid region counter.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam logic [7:0] COLOR_G = 8'h47;
    localparam logic [7:0] COLOR_R = 8'h52;
    localparam int         COUNT_W = 15;

    // Command from the top sequencer to the fill engine
    typedef struct packed {
        logic start;
        logic merge;
    } grc_cmd_t;

    // Status back from the fill engine
    typedef struct packed {
        logic                 done;
        logic [COUNT_W-1:0]   count;
    } grc_stat_t;

    function automatic logic [7:0] color_key(input logic [7:0] c, input logic merge);
        logic [7:0] k;
        k = c;
        if (merge && (c == COLOR_G)) k = COLOR_R;
        return k;
    endfunction

endpackage

/* sv/grid_region_counter_top.sv */
// ----------------------------------------------------------------------------
// grid_region_counter_top
// Loads a square grid of color bytes and counts 4-connected same-color
// regions, once as-is and once with G merged into R.
// ----------------------------------------------------------------------------
// Operation: the last load item of a grid starts two passes of the fill
//   engine; each pass sweeps the N*N seen marks, checks each start cell and
//   walks each new region through the four neighbors of its cells; the
//   result item is raised after the second pass.
// Throughput: one load item per cycle while loading; loads stall during
//   both passes, and the last item of a grid waits while a result is still
//   unaccepted. The fill engine reads colors and seen marks on one address.
// Reset: synchronous active-low; side_length returns to 1, load position and
//   counts to zero. Memories are not cleared: seen marks are swept before
//   every pass, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module grid_region_counter_top import grc_pkg::*; #(
    parameter int MAX_SIDE = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: side_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cell_color
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [14:0] normal_regions, [29:15] merged_regions
);

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int TOT_W  = $clog2(CELLS + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    // top-level sequencer
    localparam logic [1:0] T_LOAD  = 2'd0;
    localparam logic [1:0] T_PASS1 = 2'd1;
    localparam logic [1:0] T_PASS2 = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [7:0]         side_reg;
    logic [IDX_W-1:0]   load_reg, load_next;
    logic [COUNT_W-1:0] first_reg, first_next;
    logic [COUNT_W-1:0] second_reg, second_next;
    logic               mval_reg, mval_next;

    logic [SIDE_W-1:0]  side_use;
    logic [TOT_W-1:0]   total;
    logic               grid_done;
    logic               s_acc;
    grc_cmd_t           cmd;
    grc_stat_t          stat;
    logic [IDX_W-1:0]   color_raddr;
    logic [7:0]         color_rdata;

    // side in use: zero reads as one, clamp at MAX_SIDE
    always_comb begin
        if (side_reg == 8'd0) begin
            side_use = SIDE_W'(1);
        end else if (32'(side_reg) > MAX_SIDE) begin
            side_use = SIDE_W'(MAX_SIDE);
        end else begin
            side_use = SIDE_W'(side_reg);
        end
    end

    assign total     = TOT_W'(side_use) * TOT_W'(side_use);
    assign grid_done = (TOT_W'(load_reg) + TOT_W'(1)) >= total;

    // loads keep flowing while a result waits; a grid end waits for the slot
    assign s_tready  = (state_reg == T_LOAD) && !(grid_done && mval_reg);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next  = state_reg;
        load_next   = load_reg;
        first_next  = first_reg;
        second_next = second_reg;
        mval_next   = mval_reg;
        cmd.start   = 1'b0;
        cmd.merge   = 1'b0;

        if (mval_reg && m_tready) mval_next = 1'b0;

        unique case (state_reg)
            T_LOAD: begin
                if (s_acc) begin
                    if (grid_done) begin
                        load_next  = '0;
                        cmd.start  = 1'b1;
                        state_next = T_PASS1;
                    end else begin
                        load_next = load_reg + IDX_W'(1);
                    end
                end
            end
            T_PASS1: begin
                if (stat.done) begin
                    first_next = stat.count;
                    cmd.start  = 1'b1;
                    cmd.merge  = 1'b1;
                    state_next = T_PASS2;
                end
            end
            T_PASS2: begin
                if (stat.done) begin
                    second_next = stat.count;
                    mval_next   = 1'b1;
                    state_next  = T_LOAD;
                end
            end
            default: begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_LOAD;
            side_reg   <= 8'd1;
            load_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            load_reg   <= load_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            mval_reg   <= mval_next;
            if (cfg_valid && cfg_ready) begin
                side_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {2'b00, second_reg, first_reg};

    // color store: written by loads, read by the fill engine
    grc_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color (
        .aclk  (aclk),
        .we    (s_acc),
        .waddr (load_reg),
        .wdata (s_tdata),
        .raddr (color_raddr),
        .rdata (color_rdata)
    );

    grc_fill #(.MAX_SIDE(MAX_SIDE)) u_fill (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .side        (side_use),
        .total       (total),
        .color_raddr (color_raddr),
        .color_rdata (color_rdata),
        .stat        (stat)
    );

endmodule

/* sv/grc_ram.sv */
// ----------------------------------------------------------------------------
// grc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/grc_fill.sv */
// ----------------------------------------------------------------------------
// grc_fill
// Flood-fill region counter: clears visited marks, scans start cells and
// walks each region through an explicit stack held in RAM.
// ----------------------------------------------------------------------------
module grc_fill import grc_pkg::*; #(
    parameter int MAX_SIDE = 128
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  grc_cmd_t                                  cmd,
    input  logic [$clog2(MAX_SIDE+1)-1:0]             side,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]    total,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      color_raddr,
    input  logic [7:0]                                color_rdata,
    output grc_stat_t                                 stat
);

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int TOT_W  = $clog2(CELLS + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int RC_W   = $clog2(MAX_SIDE);
    localparam int STK_W  = IDX_W + 2 * RC_W;

    localparam logic [3:0] E_IDLE  = 4'd0;
    localparam logic [3:0] E_CLR   = 4'd1;
    localparam logic [3:0] E_SREAD = 4'd2;
    localparam logic [3:0] E_SCHK  = 4'd3;
    localparam logic [3:0] E_POP   = 4'd4;
    localparam logic [3:0] E_PWAIT = 4'd5;
    localparam logic [3:0] E_NSEL  = 4'd6;
    localparam logic [3:0] E_NCHK  = 4'd7;

    logic [3:0]         state_reg,  state_next;
    logic [IDX_W-1:0]   clr_reg,    clr_next;
    logic [IDX_W-1:0]   st_idx_reg, st_idx_next;
    logic [RC_W-1:0]    st_r_reg,   st_r_next;
    logic [RC_W-1:0]    st_c_reg,   st_c_next;
    logic [IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    logic [RC_W-1:0]    cur_r_reg,  cur_r_next;
    logic [RC_W-1:0]    cur_c_reg,  cur_c_next;
    logic [IDX_W-1:0]   nb_idx_reg, nb_idx_next;
    logic [RC_W-1:0]    nb_r_reg,   nb_r_next;
    logic [RC_W-1:0]    nb_c_reg,   nb_c_next;
    logic [1:0]         dir_reg,    dir_next;
    logic [TOT_W-1:0]   depth_reg,  depth_next;
    logic [7:0]         key_reg,    key_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               merge_reg,  merge_next;
    logic               done_reg,   done_next;

    logic               seen_we, seen_wdata, seen_rdata;
    logic [IDX_W-1:0]   seen_waddr, rd_addr;
    logic               stk_we;
    logic [IDX_W-1:0]   stk_waddr, stk_raddr;
    logic [STK_W-1:0]   stk_wdata, stk_rdata;

    logic [IDX_W-1:0]   last_idx;
    logic [SIDE_W-1:0]  side_m1;
    logic               st_last, st_col_last;
    logic               nb_ok;
    logic [IDX_W-1:0]   nb_idx_c;
    logic [RC_W-1:0]    nb_r_c, nb_c_c;
    logic [IDX_W-1:0]   side_x;

    assign last_idx    = IDX_W'(total - TOT_W'(1));
    assign side_m1     = side - SIDE_W'(1);
    assign side_x      = IDX_W'(side);
    assign st_last     = (st_idx_reg == last_idx);
    assign st_col_last = (SIDE_W'(st_c_reg) == side_m1);

    // neighbor of the current cell in direction dir: down, up, right, left
    always_comb begin
        nb_idx_c = cur_idx_reg;
        nb_r_c   = cur_r_reg;
        nb_c_c   = cur_c_reg;
        nb_ok    = 1'b0;
        unique case (dir_reg)
            2'd0: begin
                nb_ok    = (SIDE_W'(cur_r_reg) != side_m1);
                nb_r_c   = cur_r_reg + RC_W'(1);
                nb_idx_c = cur_idx_reg + side_x;
            end
            2'd1: begin
                nb_ok    = (cur_r_reg != '0);
                nb_r_c   = cur_r_reg - RC_W'(1);
                nb_idx_c = cur_idx_reg - side_x;
            end
            2'd2: begin
                nb_ok    = (SIDE_W'(cur_c_reg) != side_m1);
                nb_c_c   = cur_c_reg + RC_W'(1);
                nb_idx_c = cur_idx_reg + IDX_W'(1);
            end
            default: begin
                nb_ok    = (cur_c_reg != '0);
                nb_c_c   = cur_c_reg - RC_W'(1);
                nb_idx_c = cur_idx_reg - IDX_W'(1);
            end
        endcase
    end

    // shared read address for seen marks and colors
    assign rd_addr     = (state_reg == E_SREAD) ? st_idx_reg : nb_idx_c;
    assign color_raddr = rd_addr;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        st_idx_next  = st_idx_reg;
        st_r_next    = st_r_reg;
        st_c_next    = st_c_reg;
        cur_idx_next = cur_idx_reg;
        cur_r_next   = cur_r_reg;
        cur_c_next   = cur_c_reg;
        nb_idx_next  = nb_idx_reg;
        nb_r_next    = nb_r_reg;
        nb_c_next    = nb_c_reg;
        dir_next     = dir_reg;
        depth_next   = depth_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        merge_next   = merge_reg;
        done_next    = 1'b0;
        seen_we      = 1'b0;
        seen_waddr   = clr_reg;
        seen_wdata   = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = IDX_W'(depth_reg);
        stk_wdata    = {nb_idx_reg, nb_r_reg, nb_c_reg};
        stk_raddr    = IDX_W'(depth_reg - TOT_W'(1));

        unique case (state_reg)
            E_IDLE: begin
                if (cmd.start) begin
                    merge_next = cmd.merge;
                    clr_next   = '0;
                    count_next = '0;
                    state_next = E_CLR;
                end
            end
            E_CLR: begin
                seen_we    = 1'b1;
                seen_waddr = clr_reg;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == last_idx) begin
                    st_idx_next = '0;
                    st_r_next   = '0;
                    st_c_next   = '0;
                    state_next  = E_SREAD;
                end
            end
            E_SREAD: begin
                state_next = E_SCHK;
            end
            E_SCHK: begin
                if (!seen_rdata) begin
                    count_next = count_reg + COUNT_W'(1);
                    key_next   = color_key(color_rdata, merge_reg);
                    seen_we    = 1'b1;
                    seen_waddr = st_idx_reg;
                    seen_wdata = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {st_idx_reg, st_r_reg, st_c_reg};
                    depth_next = TOT_W'(1);
                    state_next = E_POP;
                end
            end
            E_POP: begin
                if (depth_reg != '0) begin
                    depth_next = depth_reg - TOT_W'(1);
                    state_next = E_PWAIT;
                end
            end
            E_PWAIT: begin
                {cur_idx_next, cur_r_next, cur_c_next} = stk_rdata;
                dir_next   = 2'd0;
                state_next = E_NSEL;
            end
            E_NSEL: begin
                nb_idx_next = nb_idx_c;
                nb_r_next   = nb_r_c;
                nb_c_next   = nb_c_c;
                if (nb_ok) begin
                    state_next = E_NCHK;
                end else if (dir_reg == 2'd3) begin
                    state_next = E_POP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            E_NCHK: begin
                if (!seen_rdata && (color_key(color_rdata, merge_reg) == key_reg)) begin
                    seen_we    = 1'b1;
                    seen_waddr = nb_idx_reg;
                    seen_wdata = 1'b1;
                    stk_we     = 1'b1;
                    depth_next = depth_reg + TOT_W'(1);
                end
                if (dir_reg == 2'd3) begin
                    state_next = E_POP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = E_NSEL;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase

        // move to the next start cell once this one is settled
        if ((state_reg == E_SCHK && seen_rdata) ||
            (state_reg == E_POP && depth_reg == '0)) begin
            if (st_last) begin
                done_next  = 1'b1;
                state_next = E_IDLE;
            end else begin
                st_idx_next = st_idx_reg + IDX_W'(1);
                if (st_col_last) begin
                    st_c_next = '0;
                    st_r_next = st_r_reg + RC_W'(1);
                end else begin
                    st_c_next = st_c_reg + RC_W'(1);
                end
                state_next = E_SREAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            depth_reg <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        clr_reg     <= clr_next;
        st_idx_reg  <= st_idx_next;
        st_r_reg    <= st_r_next;
        st_c_reg    <= st_c_next;
        cur_idx_reg <= cur_idx_next;
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        nb_idx_reg  <= nb_idx_next;
        nb_r_reg    <= nb_r_next;
        nb_c_reg    <= nb_c_next;
        dir_reg     <= dir_next;
        key_reg     <= key_next;
        merge_reg   <= merge_next;
    end

    assign stat.done  = done_reg;
    assign stat.count = count_reg;

    grc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen (
        .aclk  (aclk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (rd_addr),
        .rdata (seen_rdata)
    );

    grc_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule
